### sv/sau_pkg.sv
package sau_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int WORD_W      = 32;
    localparam int ADD_W       = WORD_W + 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int STEP_W      = $clog2(WORD_W);
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 2;
    localparam int DEPTH_W     = 7;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_cmd CMD_PUSH = 3'd0;
    localparam t_cmd CMD_ADD  = 3'd1;
    localparam t_cmd CMD_SUB  = 3'd2;
    localparam t_cmd CMD_DIV  = 3'd3;
    localparam t_cmd CMD_MUL  = 3'd4;
    localparam t_cmd CMD_MOD  = 3'd5;

    localparam t_status STATUS_OK      = 2'd0;
    localparam t_status STATUS_SHORT   = 2'd1;
    localparam t_status STATUS_DIVZERO = 2'd2;
    localparam t_status STATUS_FULL    = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_DIV,
        S_FIX,
        S_DONE
    } t_state;

endpackage

### sv/sau_cmd_if.sv
interface sau_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [sau_pkg::CMD_W-1:0]  command;
    logic signed [sau_pkg::WORD_W-1:0] push_value;

    modport source (output valid, output command, output push_value, input ready);
    modport sink   (input valid, input command, input push_value, output ready);
endinterface

### sv/sau_res_if.sv
interface sau_res_if;
    logic                          valid;
    logic                          ready;
    logic [sau_pkg::STATUS_W-1:0]  status;
    logic signed [sau_pkg::WORD_W-1:0] top_value;
    logic [sau_pkg::DEPTH_W-1:0]   stack_depth;

    modport source (output valid, output status, output top_value, output stack_depth,
                    input ready);
    modport sink   (input valid, input status, input top_value, input stack_depth,
                    output ready);
endinterface

### sv/stack_arithmetic_unit.sv
// Stack of 64 signed 32-bit words driven by push/add/sub/div/mul/mod commands,
// one result transfer per command. All entries sit in a RAM with one write and
// one read port; the top entry is also held in a register. Push, errors and
// unused codes go straight to the done state; add and sub pass through the load
// and fix states, and mul, div and mod also run the 32-step shift-add /
// restoring-divide loop on the one shared 33-bit adder between load and fix.
// The done state waits while the output register holds an untaken result.
// A new command is taken only when the sequencer is idle; a finished result
// may still sit in the output register while the next command is accepted.
module stack_arithmetic_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sau_cmd_if.sink   i_cmd,
    sau_res_if.source o_res
);

    logic [sau_pkg::WORD_W-1:0] r_mem [sau_pkg::STACK_DEPTH];
    logic [sau_pkg::WORD_W-1:0] r_rd;

    sau_pkg::t_state            r_state, n_state;
    logic [sau_pkg::CNT_W-1:0]  r_count, n_count;
    logic [sau_pkg::WORD_W-1:0] r_top, n_top;
    sau_pkg::t_status           r_status, n_status;
    sau_pkg::t_cmd              r_cmd, n_cmd;
    logic [sau_pkg::WORD_W-1:0] r_rem, n_rem;
    logic [sau_pkg::WORD_W-1:0] r_quo, n_quo;
    logic [sau_pkg::WORD_W-1:0] r_dvs, n_dvs;
    logic                       r_neg_q, n_neg_q;
    logic                       r_neg_r, n_neg_r;
    logic [sau_pkg::STEP_W-1:0] r_step, n_step;

    logic                        r_out_valid, n_out_valid;
    sau_pkg::t_status            r_out_status, n_out_status;
    logic [sau_pkg::WORD_W-1:0]  r_out_top, n_out_top;
    logic [sau_pkg::DEPTH_W-1:0] r_out_depth, n_out_depth;

    logic                       w_we;
    logic [sau_pkg::IDX_W-1:0]  w_addr;
    logic [sau_pkg::WORD_W-1:0] w_data;
    logic [sau_pkg::CNT_W-1:0]  w_cnt_m2;
    logic [sau_pkg::IDX_W-1:0]  w_rd_addr;
    logic                       w_fix_neg;

    logic [sau_pkg::ADD_W-1:0]  add_a, add_b, add_sum;
    logic                       add_sub;

    localparam logic [sau_pkg::STEP_W-1:0] STEP_LAST = sau_pkg::STEP_W'(sau_pkg::WORD_W - 1);

    assign w_cnt_m2  = r_count - sau_pkg::CNT_W'(2);
    assign w_rd_addr = w_cnt_m2[sau_pkg::IDX_W-1:0];

    // shared adder / subtractor
    assign add_sum = add_a + (add_sub ? ~add_b : add_b) + sau_pkg::ADD_W'(add_sub);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_data;
        end
        r_rd <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sau_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top        <= n_top;
        r_status     <= n_status;
        r_cmd        <= n_cmd;
        r_rem        <= n_rem;
        r_quo        <= n_quo;
        r_dvs        <= n_dvs;
        r_neg_q      <= n_neg_q;
        r_neg_r      <= n_neg_r;
        r_step       <= n_step;
        r_out_status <= n_out_status;
        r_out_top    <= n_out_top;
        r_out_depth  <= n_out_depth;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_top        = r_top;
        n_status     = r_status;
        n_cmd        = r_cmd;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_dvs        = r_dvs;
        n_neg_q      = r_neg_q;
        n_neg_r      = r_neg_r;
        n_step       = r_step;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_top    = r_out_top;
        n_out_depth  = r_out_depth;
        w_we         = 1'b0;
        w_addr       = r_count[sau_pkg::IDX_W-1:0];
        w_data       = r_top;
        w_fix_neg    = 1'b0;
        add_a        = '0;
        add_b        = '0;
        add_sub      = 1'b0;

        if (o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            sau_pkg::S_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd    = i_cmd.command;
                    n_status = sau_pkg::STATUS_OK;
                    n_state  = sau_pkg::S_DONE;
                    case (i_cmd.command)
                        sau_pkg::CMD_PUSH: begin
                            if (r_count >= sau_pkg::CNT_W'(sau_pkg::STACK_DEPTH)) begin
                                n_status = sau_pkg::STATUS_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_addr  = r_count[sau_pkg::IDX_W-1:0];
                                w_data  = i_cmd.push_value;
                                n_top   = i_cmd.push_value;
                                n_count = r_count + sau_pkg::CNT_W'(1);
                            end
                        end
                        sau_pkg::CMD_ADD, sau_pkg::CMD_SUB, sau_pkg::CMD_MUL: begin
                            if (r_count < sau_pkg::CNT_W'(2)) begin
                                n_status = sau_pkg::STATUS_SHORT;
                            end else begin
                                n_state = sau_pkg::S_LOAD;
                            end
                        end
                        sau_pkg::CMD_DIV, sau_pkg::CMD_MOD: begin
                            if (r_count < sau_pkg::CNT_W'(2)) begin
                                n_status = sau_pkg::STATUS_SHORT;
                            end else if (r_top == '0) begin
                                n_status = sau_pkg::STATUS_DIVZERO;
                            end else begin
                                n_state = sau_pkg::S_LOAD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            sau_pkg::S_LOAD: begin
                // r_rd holds the second entry
                add_a   = {1'b0, r_rd};
                add_b   = {1'b0, r_top};
                add_sub = (r_cmd == sau_pkg::CMD_SUB);
                n_rem   = add_sum[sau_pkg::WORD_W-1:0];
                n_step  = '0;
                n_neg_q = r_rd[sau_pkg::WORD_W-1] ^ r_top[sau_pkg::WORD_W-1];
                n_neg_r = r_rd[sau_pkg::WORD_W-1];
                case (r_cmd)
                    sau_pkg::CMD_MUL: begin
                        n_quo   = r_top;
                        n_dvs   = r_rd;
                        n_rem   = '0;
                        n_state = sau_pkg::S_MUL;
                    end
                    sau_pkg::CMD_DIV, sau_pkg::CMD_MOD: begin
                        n_quo   = r_rd[sau_pkg::WORD_W-1] ? -r_rd : r_rd;
                        n_dvs   = r_top[sau_pkg::WORD_W-1] ? -r_top : r_top;
                        n_rem   = '0;
                        n_state = sau_pkg::S_DIV;
                    end
                    default: begin
                        n_state = sau_pkg::S_FIX;
                    end
                endcase
            end
            sau_pkg::S_MUL: begin
                add_a  = {1'b0, r_rem};
                add_b  = r_quo[0] ? {1'b0, r_dvs} : '0;
                n_rem  = add_sum[sau_pkg::WORD_W-1:0];
                n_dvs  = {r_dvs[sau_pkg::WORD_W-2:0], 1'b0};
                n_quo  = {1'b0, r_quo[sau_pkg::WORD_W-1:1]};
                n_step = r_step + sau_pkg::STEP_W'(1);
                if (r_step == STEP_LAST) begin
                    n_state = sau_pkg::S_FIX;
                end
            end
            sau_pkg::S_DIV: begin
                add_a   = {r_rem, r_quo[sau_pkg::WORD_W-1]};
                add_b   = {1'b0, r_dvs};
                add_sub = 1'b1;
                if (!add_sum[sau_pkg::WORD_W]) begin
                    n_rem = add_sum[sau_pkg::WORD_W-1:0];
                end else begin
                    n_rem = {r_rem[sau_pkg::WORD_W-2:0], r_quo[sau_pkg::WORD_W-1]};
                end
                n_quo  = {r_quo[sau_pkg::WORD_W-2:0], !add_sum[sau_pkg::WORD_W]};
                n_step = r_step + sau_pkg::STEP_W'(1);
                if (r_step == STEP_LAST) begin
                    n_state = sau_pkg::S_FIX;
                end
            end
            sau_pkg::S_FIX: begin
                // sign fix and write-back over the top two entries
                add_sub = 1'b1;
                add_b   = {1'b0, (r_cmd == sau_pkg::CMD_DIV) ? r_quo : r_rem};
                case (r_cmd)
                    sau_pkg::CMD_DIV: w_fix_neg = r_neg_q;
                    sau_pkg::CMD_MOD: w_fix_neg = r_neg_r;
                    default:          w_fix_neg = 1'b0;
                endcase
                w_data  = w_fix_neg ? add_sum[sau_pkg::WORD_W-1:0]
                                    : add_b[sau_pkg::WORD_W-1:0];
                w_we    = 1'b1;
                w_addr  = w_rd_addr;
                n_top   = w_data;
                n_count = r_count - sau_pkg::CNT_W'(1);
                n_state = sau_pkg::S_DONE;
            end
            sau_pkg::S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_top    = (r_count == '0) ? '0 : r_top;
                    n_out_depth  = sau_pkg::DEPTH_W'(r_count);
                    n_state      = sau_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sau_pkg::S_IDLE;
            end
        endcase
    end

    assign i_cmd.ready       = (r_state == sau_pkg::S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out_status;
    assign o_res.top_value   = r_out_top;
    assign o_res.stack_depth = r_out_depth;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sau_pkg::CNT_W'(sau_pkg::STACK_DEPTH))
        else $error("stack count beyond depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count) ||
                            r_count == $past(r_count) + sau_pkg::CNT_W'(1) ||
                            r_count == $past(r_count) - sau_pkg::CNT_W'(1)))
        else $error("stack count moved by more than one");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == sau_pkg::S_DONE)
        else $error("result loaded outside done state");

endmodule
